// ----- hw/rtl/ps2mct_pkg.sv -----
package ps2mct_pkg;

	// Field widths fixed by the item format
	localparam int unsigned SIZE_BITS    = 13;
	localparam int unsigned SET_BITS     = 16;
	localparam int unsigned DELTA_BITS   = 9;
	localparam int unsigned CFG_IDX_BITS = 1;
	localparam int unsigned CFG_DATA_BITS = SIZE_BITS;

	// Default coordinate width and screen size after reset
	localparam int unsigned COORD_BITS_DEFAULT = 12;
	localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd320;
	localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd200;

	// Status byte bits
	localparam int unsigned LEFT_IDX   = 0;
	localparam int unsigned RIGHT_IDX  = 1;
	localparam int unsigned MIDDLE_IDX = 2;
	localparam int unsigned SYNC_IDX   = 3;
	localparam int unsigned X_SIGN_IDX = 4;
	localparam int unsigned Y_SIGN_IDX = 5;
	localparam int unsigned X_OVF_IDX  = 6;
	localparam int unsigned Y_OVF_IDX  = 7;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SCREEN_WIDTH  = 1'd0,
		CFG_SCREEN_HEIGHT = 1'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		KIND_STORED   = 3'd0,
		KIND_RESYNC   = 3'd1,
		KIND_APPLIED  = 3'd2,
		KIND_OVERFLOW = 3'd3,
		KIND_SET      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		POS_STATUS = 2'd0,
		POS_X      = 2'd1,
		POS_Y      = 2'd2
	} byte_pos_t;

	typedef enum logic {
		FUNC_BYTE = 1'b0,
		FUNC_SET  = 1'b1
	} func_t;

endpackage

// ----- hw/rtl/ps2mct_item_if.sv -----
interface ps2mct_item_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic [7:0]                          data_byte;
	logic signed [ps2mct_pkg::SET_BITS-1:0] set_x;
	logic signed [ps2mct_pkg::SET_BITS-1:0] set_y;

	modport source (output valid, func, data_byte, set_x, set_y, input ready);
	modport sink (input valid, func, data_byte, set_x, set_y, output ready);
endinterface

// ----- hw/rtl/ps2mct_result_if.sv -----
interface ps2mct_result_if #(
	parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            result_kind;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic                  left_pressed;
	logic                  right_pressed;
	logic                  middle_pressed;

	modport source (output valid, result_kind, cursor_x, cursor_y, left_pressed,
		right_pressed, middle_pressed, input ready);
	modport sink (input valid, result_kind, cursor_x, cursor_y, left_pressed,
		right_pressed, middle_pressed, output ready);
endinterface

// ----- hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv -----
// PS/2 mouse cursor tracker. Each transfer on the mouse channel is either a raw mouse
// byte or a direct cursor placement; every transfer yields exactly one transfer on the
// cursor channel with the result kind, the cursor position and the latched buttons.
// Bytes are gathered into status/X/Y packets; a first byte without the sync bit is
// dropped, packets with an overflow bit are discarded, and applied moves are clamped
// to the screen size set through the write port (0 counts as 1, sizes above
// 2^COORD_BITS count as 2^COORD_BITS). A new size takes effect on the next move or
// placement. One item is accepted every cycle while the cursor channel is not stalled; an
// item is held in the input register while the cursor channel stalls and then moves into
// the result register, from which its result is offered. The combinational add-and-clamp
// between those two registers is the critical path.
module ps2_mouse_packet_cursor_tracker_top #(
	parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ps2mct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	ps2mct_item_if.sink                           mouse,
	ps2mct_result_if.source                       cursor
);

	localparam int unsigned SB = ps2mct_pkg::SIZE_BITS;
	localparam int unsigned VW = (COORD_BITS + 2 > ps2mct_pkg::SET_BITS + 1) ?
		COORD_BITS + 2 : ps2mct_pkg::SET_BITS + 1;
	localparam int unsigned EW = ((COORD_BITS > SB) ? COORD_BITS : SB) + 1;
	localparam logic [EW-1:0] FULL_SIZE = EW'(1) << COORD_BITS;

	// Clamp a signed value into [0, lim_m1]
	function automatic logic [COORD_BITS-1:0] clamp_coord(
		input logic signed [VW-1:0] v,
		input logic [COORD_BITS-1:0] lim_m1
	);
		logic signed [VW-1:0] lim_s;
		lim_s = $signed({{(VW-COORD_BITS){1'b0}}, lim_m1});
		if (v < 0)
			return '0;
		else if (v > lim_s)
			return lim_m1;
		else
			return v[COORD_BITS-1:0];
	endfunction

	// Largest coordinate allowed by a screen size
	function automatic logic [COORD_BITS-1:0] max_coord(input logic [SB-1:0] size);
		logic [EW-1:0] size_e;
		size_e = EW'(size);
		if (size_e == '0)
			return '0;
		else if (size_e > FULL_SIZE)
			return '1;
		else
			return COORD_BITS'(size_e - EW'(1));
	endfunction

	// Configuration registers
	logic [SB-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ps2mct_pkg::RESET_WIDTH;
			height_q <= ps2mct_pkg::RESET_HEIGHT;
		end else if (cfg_we) begin
			case (ps2mct_pkg::cfg_idx_t'(cfg_index))
				ps2mct_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				ps2mct_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	logic                                valid_s1;
	logic                                func_s1;
	logic [7:0]                          data_s1;
	logic signed [ps2mct_pkg::SET_BITS-1:0] set_x_s1, set_y_s1;
	logic                                out_free, adv_s1;

	assign out_free    = !cursor.valid || cursor.ready;
	assign adv_s1      = valid_s1 && out_free;
	assign mouse.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (mouse.ready)
			valid_s1 <= mouse.valid;
	end

	always_ff @(posedge clk) begin
		if (mouse.valid && mouse.ready) begin
			func_s1  <= mouse.func;
			data_s1  <= mouse.data_byte;
			set_x_s1 <= mouse.set_x;
			set_y_s1 <= mouse.set_y;
		end
	end

	// Tracker state
	ps2mct_pkg::byte_pos_t  bpos_q, bpos_d;
	logic [7:0]             status_q, status_d;
	logic [7:0]             xbyte_q, xbyte_d;
	logic [COORD_BITS-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
	logic [2:0]             buttons_q, buttons_d;
	ps2mct_pkg::kind_t      kind_c;

	logic [COORD_BITS-1:0]  max_x, max_y;
	logic signed [VW-1:0]   px_e, py_e, dx_e, dy_e, sx_e, sy_e;

	assign max_x = max_coord(width_q);
	assign max_y = max_coord(height_q);
	assign px_e  = $signed({{(VW-COORD_BITS){1'b0}}, pos_x_q});
	assign py_e  = $signed({{(VW-COORD_BITS){1'b0}}, pos_y_q});
	assign dx_e  = $signed({{(VW-ps2mct_pkg::DELTA_BITS+1){status_q[ps2mct_pkg::X_SIGN_IDX]}},
		xbyte_q});
	assign dy_e  = $signed({{(VW-ps2mct_pkg::DELTA_BITS+1){status_q[ps2mct_pkg::Y_SIGN_IDX]}},
		data_s1});
	assign sx_e  = $signed({{(VW-ps2mct_pkg::SET_BITS){set_x_s1[ps2mct_pkg::SET_BITS-1]}},
		set_x_s1});
	assign sy_e  = $signed({{(VW-ps2mct_pkg::SET_BITS){set_y_s1[ps2mct_pkg::SET_BITS-1]}},
		set_y_s1});

	// Decode the item held in the input register
	always_comb begin
		bpos_d    = bpos_q;
		status_d  = status_q;
		xbyte_d   = xbyte_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		buttons_d = buttons_q;
		kind_c    = ps2mct_pkg::KIND_STORED;
		if (ps2mct_pkg::func_t'(func_s1) == ps2mct_pkg::FUNC_SET) begin
			pos_x_d = clamp_coord(sx_e, max_x);
			pos_y_d = clamp_coord(sy_e, max_y);
			kind_c  = ps2mct_pkg::KIND_SET;
		end else begin
			case (bpos_q)
				ps2mct_pkg::POS_STATUS: begin
					if (!data_s1[ps2mct_pkg::SYNC_IDX]) begin
						kind_c = ps2mct_pkg::KIND_RESYNC;
					end else begin
						status_d = data_s1;
						bpos_d   = ps2mct_pkg::POS_X;
					end
				end
				ps2mct_pkg::POS_X: begin
					xbyte_d = data_s1;
					bpos_d  = ps2mct_pkg::POS_Y;
				end
				default: begin
					bpos_d = ps2mct_pkg::POS_STATUS;
					if (status_q[ps2mct_pkg::X_OVF_IDX] || status_q[ps2mct_pkg::Y_OVF_IDX]) begin
						kind_c = ps2mct_pkg::KIND_OVERFLOW;
					end else begin
						pos_x_d   = clamp_coord(px_e + dx_e, max_x);
						pos_y_d   = clamp_coord(py_e - dy_e, max_y);
						buttons_d = status_q[2:0];
						kind_c    = ps2mct_pkg::KIND_APPLIED;
					end
				end
			endcase
		end
	end

	// Advance state as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q    <= ps2mct_pkg::POS_STATUS;
			status_q  <= '0;
			xbyte_q   <= '0;
			pos_x_q   <= COORD_BITS'(ps2mct_pkg::RESET_WIDTH >> 1);
			pos_y_q   <= COORD_BITS'(ps2mct_pkg::RESET_HEIGHT >> 1);
			buttons_q <= '0;
		end else if (adv_s1) begin
			bpos_q    <= bpos_d;
			status_q  <= status_d;
			xbyte_q   <= xbyte_d;
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			buttons_q <= buttons_d;
		end
	end

	// Result register
	logic                   res_valid_q;
	logic [2:0]             res_kind_q;
	logic [COORD_BITS-1:0]  res_x_q, res_y_q;
	logic [2:0]             res_btn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_kind_q <= kind_c;
			res_x_q    <= pos_x_d;
			res_y_q    <= pos_y_d;
			res_btn_q  <= buttons_d;
		end
	end

	assign cursor.valid          = res_valid_q;
	assign cursor.result_kind    = res_kind_q;
	assign cursor.cursor_x       = res_x_q;
	assign cursor.cursor_y       = res_y_q;
	assign cursor.left_pressed   = res_btn_q[ps2mct_pkg::LEFT_IDX];
	assign cursor.right_pressed  = res_btn_q[ps2mct_pkg::RIGHT_IDX];
	assign cursor.middle_pressed = res_btn_q[ps2mct_pkg::MIDDLE_IDX];

	// Overflow drops leave the buttons alone
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && kind_c == ps2mct_pkg::KIND_OVERFLOW |=> $stable(buttons_q))
		else $error("buttons changed on overflow drop");

	// A resync drop keeps the tracker waiting for a status byte
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && kind_c == ps2mct_pkg::KIND_RESYNC |=> bpos_q == ps2mct_pkg::POS_STATUS)
		else $error("resync drop left packet assembly");

	// A held item is not lost while the result register is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("item lost from input register");

	// The reported position is the tracked position
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res_x_q == pos_x_q && res_y_q == pos_y_q && res_btn_q == buttons_q)
		else $error("result does not match tracked state");

endmodule

// ----- test/tb_ps2_mouse_packet_cursor_tracker_top.sv -----
module tb_ps2_mouse_packet_cursor_tracker_top;

	localparam int unsigned COORD = ps2mct_pkg::COORD_BITS_DEFAULT;
	localparam int unsigned SB = ps2mct_pkg::SIZE_BITS;
	localparam int unsigned STB = ps2mct_pkg::SET_BITS;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 90;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		ps2mct_pkg::func_t     func;
		logic [7:0]            data_byte;
		logic signed [STB-1:0] set_x;
		logic signed [STB-1:0] set_y;
	} mouse_item_t;

	typedef struct {
		ps2mct_pkg::kind_t kind;
		logic [COORD-1:0]  x;
		logic [COORD-1:0]  y;
		logic              left;
		logic              right;
		logic              middle;
	} cursor_report_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ps2mct_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [ps2mct_pkg::CFG_DATA_BITS-1:0] cfg_data;

	ps2mct_item_if mouse_ch ();
	ps2mct_result_if #(.COORD_BITS(COORD)) cursor_ch ();

	ps2_mouse_packet_cursor_tracker_top #(.COORD_BITS(COORD)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mouse     (mouse_ch),
		.cursor    (cursor_ch)
	);

	// Tracker state as the block should hold it
	logic [SB-1:0]         scr_w;
	logic [SB-1:0]         scr_h;
	ps2mct_pkg::byte_pos_t pkt_pos;
	logic [7:0]            held_status;
	logic [7:0]            held_x;
	logic [COORD-1:0]      pos_x;
	logic [COORD-1:0]      pos_y;
	logic [2:0]            buttons;

	mouse_item_t    mouse_pending[$];
	cursor_report_t cursor_due[$];
	int             offers_made;
	int             transfers_in;
	int             cursor_errors;
	logic           calm;
	logic           hold_off;

	// Clamp a coordinate into a screen dimension; zero counts as one, oversize as full range
	function automatic logic [COORD-1:0] fit_screen(input int v, input logic [SB-1:0] size);
		int lim;
		lim = (size == 0) ? 1 : int'(size);
		if (lim > (1 << COORD))
			lim = 1 << COORD;
		if (v < 0)
			v = 0;
		if (v >= lim)
			v = lim - 1;
		return v[COORD-1:0];
	endfunction

	// Advance the tracker by one item and report the cursor afterwards
	function automatic cursor_report_t track_cursor(input mouse_item_t it);
		cursor_report_t r;
		int dx;
		int dy;
		int half;
		half = 1 << (ps2mct_pkg::DELTA_BITS - 1);
		if (it.func == ps2mct_pkg::FUNC_SET) begin
			pos_x = fit_screen(int'(it.set_x), scr_w);
			pos_y = fit_screen(int'(it.set_y), scr_h);
			r.kind = ps2mct_pkg::KIND_SET;
		end else if (pkt_pos == ps2mct_pkg::POS_STATUS) begin
			if (!it.data_byte[ps2mct_pkg::SYNC_IDX]) begin
				r.kind = ps2mct_pkg::KIND_RESYNC;
			end else begin
				held_status = it.data_byte;
				pkt_pos = ps2mct_pkg::POS_X;
				r.kind = ps2mct_pkg::KIND_STORED;
			end
		end else if (pkt_pos == ps2mct_pkg::POS_X) begin
			held_x = it.data_byte;
			pkt_pos = ps2mct_pkg::POS_Y;
			r.kind = ps2mct_pkg::KIND_STORED;
		end else begin
			pkt_pos = ps2mct_pkg::POS_STATUS;
			if (held_status[ps2mct_pkg::X_OVF_IDX] || held_status[ps2mct_pkg::Y_OVF_IDX]) begin
				r.kind = ps2mct_pkg::KIND_OVERFLOW;
			end else begin
				dx = int'(held_x) - (held_status[ps2mct_pkg::X_SIGN_IDX] ? half : 0);
				dy = int'(it.data_byte) - (held_status[ps2mct_pkg::Y_SIGN_IDX] ? half : 0);
				pos_x = fit_screen(int'(pos_x) + dx, scr_w);
				pos_y = fit_screen(int'(pos_y) - dy, scr_h);
				buttons = {held_status[ps2mct_pkg::MIDDLE_IDX],
					held_status[ps2mct_pkg::RIGHT_IDX], held_status[ps2mct_pkg::LEFT_IDX]};
				r.kind = ps2mct_pkg::KIND_APPLIED;
			end
		end
		r.x = pos_x;
		r.y = pos_y;
		r.left = buttons[0];
		r.right = buttons[1];
		r.middle = buttons[2];
		return r;
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		mouse_item_t it;
		it.func = ps2mct_pkg::FUNC_BYTE;
		it.data_byte = b;
		it.set_x = STB'($urandom);
		it.set_y = STB'($urandom);
		mouse_pending.push_back(it);
	endtask

	task automatic queue_set(input logic signed [STB-1:0] x, input logic signed [STB-1:0] y);
		mouse_item_t it;
		it.func = ps2mct_pkg::FUNC_SET;
		it.data_byte = 8'($urandom);
		it.set_x = x;
		it.set_y = y;
		mouse_pending.push_back(it);
	endtask

	// Half the time near the screen edges, otherwise anywhere in the 16-bit range
	function automatic logic signed [STB-1:0] pick_coord(input logic [SB-1:0] size);
		if ($urandom_range(0, 99) < 50)
			return STB'(int'($urandom_range(0, int'(size) + 64)) - 32);
		return STB'($urandom);
	endfunction

	task automatic write_screen(input logic [SB-1:0] w, input logic [SB-1:0] h);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ps2mct_pkg::CFG_SCREEN_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= ps2mct_pkg::CFG_SCREEN_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		scr_w = w;
		scr_h = h;
	endtask

	task automatic wait_drained();
		while (!(mouse_pending.size() == 0 && offers_made == transfers_in &&
			cursor_due.size() == 0))
			@(negedge clk);
	endtask

	// Mostly well-formed packets with random content, plus placements, noise and stray bytes
	task automatic queue_random(input int n_items);
		int n;
		int pick;
		logic [7:0] st;
		n = 0;
		while (n < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				st = 8'($urandom) | (8'h1 << ps2mct_pkg::SYNC_IDX);
				if ($urandom_range(0, 99) < 80) begin
					st[ps2mct_pkg::X_OVF_IDX] = 1'b0;
					st[ps2mct_pkg::Y_OVF_IDX] = 1'b0;
				end
				queue_byte(st);
				if ($urandom_range(0, 99) < 8)
					queue_set(pick_coord(scr_w), pick_coord(scr_h));
				queue_byte(8'($urandom));
				if ($urandom_range(0, 99) < 5)
					queue_set(pick_coord(scr_w), pick_coord(scr_h));
				queue_byte(8'($urandom));
				n += 3;
			end else if (pick < 80) begin
				queue_set(pick_coord(scr_w), pick_coord(scr_h));
				n++;
			end else if (pick < 92) begin
				queue_byte(8'($urandom) & ~(8'h1 << ps2mct_pkg::SYNC_IDX));
				n++;
			end else begin
				queue_byte(8'($urandom));
				n++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer the next pending item once the previous one has been taken
	always @(negedge clk) begin
		mouse_item_t nxt;
		if (offers_made == transfers_in) begin
			if (arst_n && mouse_pending.size() > 0 &&
				(calm || $urandom_range(0, 99) >= 10)) begin
				nxt = mouse_pending.pop_front();
				mouse_ch.func <= nxt.func;
				mouse_ch.data_byte <= nxt.data_byte;
				mouse_ch.set_x <= nxt.set_x;
				mouse_ch.set_y <= nxt.set_y;
				mouse_ch.valid <= 1'b1;
				offers_made <= offers_made + 1;
			end else begin
				mouse_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the cursor channel at random, or hold it off entirely
	always @(negedge clk) begin
		cursor_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 10);
	end

	// Check each cursor transfer, then predict from each mouse transfer
	always @(posedge clk) begin
		cursor_report_t want;
		mouse_item_t got;
		if (arst_n) begin
			if (cursor_ch.valid && cursor_ch.ready) begin
				if (cursor_due.size() == 0) begin
					cursor_errors++;
					if (cursor_errors <= 10)
						$display("unexpected cursor transfer: kind %0d x %0d y %0d",
							cursor_ch.result_kind, cursor_ch.cursor_x, cursor_ch.cursor_y);
				end else begin
					want = cursor_due.pop_front();
					if (cursor_ch.result_kind != want.kind || cursor_ch.cursor_x != want.x ||
						cursor_ch.cursor_y != want.y || cursor_ch.left_pressed != want.left ||
						cursor_ch.right_pressed != want.right ||
						cursor_ch.middle_pressed != want.middle) begin
						cursor_errors++;
						if (cursor_errors <= 10)
							$display({"cursor mismatch: expected kind %0d x %0d y %0d lrm %b%b%b,",
								" got kind %0d x %0d y %0d lrm %b%b%b"},
								want.kind, want.x, want.y, want.left, want.right, want.middle,
								cursor_ch.result_kind, cursor_ch.cursor_x, cursor_ch.cursor_y,
								cursor_ch.left_pressed, cursor_ch.right_pressed,
								cursor_ch.middle_pressed);
					end
				end
			end
			if (mouse_ch.valid && mouse_ch.ready) begin
				got.func = ps2mct_pkg::func_t'(mouse_ch.func);
				got.data_byte = mouse_ch.data_byte;
				got.set_x = mouse_ch.set_x;
				got.set_y = mouse_ch.set_y;
				cursor_due.push_back(track_cursor(got));
				transfers_in <= transfers_in + 1;
			end
		end
	end

	// Hold off the cursor channel for a long stretch so the block backs up
	initial begin
		hold_off = 1'b0;
		wait (transfers_in >= 120);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_ps2_mouse_packet_cursor_tracker_top: FAIL");
		$finish;
	end

	initial begin
		logic [SB-1:0] widths[PHASES];
		logic [SB-1:0] heights[PHASES];
		widths = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd0, 13'd320};
		heights = '{13'd0, 13'd4097, 13'd4096, 13'd1, 13'd0, 13'd200};
		widths[4] = SB'($urandom_range(1, 4096));
		heights[4] = SB'($urandom_range(1, 4096));

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ps2mct_pkg::CFG_SCREEN_WIDTH;
		cfg_data = '0;
		mouse_ch.valid = 1'b0;
		mouse_ch.func = ps2mct_pkg::FUNC_BYTE;
		mouse_ch.data_byte = '0;
		mouse_ch.set_x = '0;
		mouse_ch.set_y = '0;
		cursor_ch.ready = 1'b0;
		calm = 1'b0;
		offers_made = 0;
		transfers_in = 0;
		cursor_errors = 0;

		scr_w = ps2mct_pkg::RESET_WIDTH;
		scr_h = ps2mct_pkg::RESET_HEIGHT;
		pkt_pos = ps2mct_pkg::POS_STATUS;
		held_status = '0;
		held_x = '0;
		pos_x = COORD'(ps2mct_pkg::RESET_WIDTH / 2);
		pos_y = COORD'(ps2mct_pkg::RESET_HEIGHT / 2);
		buttons = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Resync drops: nothing set, then everything but the sync bit
		queue_byte(8'h00);
		queue_byte(8'hF7);
		// Largest positive move with all buttons, clamping at right and top
		queue_byte(8'h0F);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		// Largest negative move, clamping at the bottom
		queue_byte(8'h38);
		queue_byte(8'h00);
		queue_byte(8'h00);
		// Zero move with buttons released
		queue_byte(8'h08);
		queue_byte(8'h00);
		queue_byte(8'h00);
		// Overflow drops on X and on Y
		queue_byte(8'h4B);
		queue_byte(8'h12);
		queue_byte(8'h34);
		queue_byte(8'h8C);
		queue_byte(8'h56);
		queue_byte(8'h78);
		// Placement in the middle of a packet, then the packet completes
		queue_byte(8'h09);
		queue_set(16'sh8000, 16'sh7FFF);
		queue_byte(8'h10);
		queue_byte(8'h80);
		// Placements at the extremes
		queue_set(16'sh7FFF, 16'sh8000);
		queue_set(16'sh0000, 16'sh0000);
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_screen(widths[ph], heights[ph]);
			calm <= (ph == 3);
			@(posedge clk);
			queue_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (cursor_errors == 0 && cursor_due.size() == 0)
			$display("tb_ps2_mouse_packet_cursor_tracker_top: PASS");
		else
			$display("tb_ps2_mouse_packet_cursor_tracker_top: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/ps2mct_pkg.sv
hw/rtl/ps2mct_item_if.sv
hw/rtl/ps2mct_result_if.sv
hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv
test/tb_ps2_mouse_packet_cursor_tracker_top.sv
